// ===== rtl/core/chtrk_pkg.sv =====
// ----------------------------------------------------------------------------
// Cache hit tracker package
// Shared widths, configuration register indexes and the control bundles that
// pass between the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package chtrk_pkg;

  // Default geometry: 64 blocks of 64-byte lines.
  localparam int DEF_MAX_BLOCKS  = 64;
  localparam int DEF_OFFSET_BITS = 6;

  localparam int ADDR_W     = 32;
  localparam int CNT_W      = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;

  // Level of the block count (log2). The largest cache the configuration
  // field can select has 128 blocks, so a level fits in four bits.
  localparam int LVL_W = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FULLY_ASSOC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPLIT       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_LOG2 = 2'd2;

  localparam logic [CFG_DATA_W-1:0] BLOCKS_LOG2_RESET = 3'd6;

  typedef struct packed {
    logic                  fully_assoc;
    logic                  split;
    logic [CFG_DATA_W-1:0] blocks_log2;
  } chtrk_cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the word and compare all tags
    logic update;   // write the tag on a miss, bump the totals
  } chtrk_cmd_t;

endpackage

// ===== rtl/core/chtrk_ctrl.sv =====
// ----------------------------------------------------------------------------
// Cache hit tracker controller
// Two-state sequencer: compare on acceptance, update in the following cycle.
// ----------------------------------------------------------------------------
module chtrk_ctrl import chtrk_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  output logic       out_valid,
  output chtrk_cmd_t cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy        = (state_r == ST_UPDATE);
  assign out_valid   = out_valid_r;
  assign cmd.capture = start && (state_r == ST_IDLE);
  assign cmd.update  = (state_r == ST_UPDATE);

endmodule

// ===== rtl/core/chtrk_datapath.sv =====
// ----------------------------------------------------------------------------
// Cache hit tracker datapath
// Tag cells with one comparator each, valid bits, FIFO pointers and totals.
// ----------------------------------------------------------------------------
module chtrk_datapath import chtrk_pkg::*; #(
  parameter int MAX_BLOCKS  = DEF_MAX_BLOCKS,
  parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  chtrk_cmd_t        cmd,
  input  chtrk_cfg_t        cfg,
  input  logic [ADDR_W-1:0] in_address,
  input  logic              in_is_instruction,
  output logic              out_hit,
  output logic [CNT_W-1:0]  out_access_total,
  output logic [CNT_W-1:0]  out_hit_total
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int LMAX  = $clog2(MAX_BLOCKS + 1) - 1;
  localparam int TAG_W = ADDR_W - OFFSET_BITS;
  localparam logic [LVL_W-1:0] LMAX_L = LVL_W'(LMAX);

  // Tag cells: no reset, every read is qualified by its valid bit.
  logic [TAG_W-1:0]      tag_cell [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] valid_r;
  logic [IDX_W-1:0]      fifo_r [2];
  logic [CNT_W-1:0]      acc_cnt_r;
  logic [CNT_W-1:0]      hit_cnt_r;
  logic                  out_hit_r;

  // Word captured at acceptance.
  logic                  hit_pend_r;
  logic [TAG_W-1:0]      tag_r;
  logic [IDX_W-1:0]      slot_r;
  logic [IDX_W-1:0]      base_r;
  logic [IDX_W-1:0]      mask_r;
  logic                  which_r;
  logic                  fa_r;

  // Geometry from the configuration.
  logic [LVL_W-1:0]  lvl;
  logic [LVL_W-1:0]  k;
  logic [IDX_W:0]    mask_wide;
  logic [IDX_W-1:0]  mask;
  logic              which;
  logic [IDX_W-1:0]  base;
  logic [TAG_W-1:0]  line;
  logic [IDX_W-1:0]  dm_slot;
  logic [TAG_W-1:0]  cmp_tag;
  logic [MAX_BLOCKS-1:0] match;

  always_comb begin
    if (cfg.blocks_log2 == '0) begin
      lvl = LVL_W'(1);
    end else if (LVL_W'(cfg.blocks_log2) > LMAX_L) begin
      lvl = LMAX_L;
    end else begin
      lvl = LVL_W'(cfg.blocks_log2);
    end
    k         = cfg.split ? (lvl - LVL_W'(1)) : lvl;
    mask_wide = ({{IDX_W{1'b0}}, 1'b1} << k) - {{IDX_W{1'b0}}, 1'b1};
    mask      = mask_wide[IDX_W-1:0];
    which     = cfg.split & in_is_instruction;
    base      = which ? (mask + IDX_W'(1)) : '0;
    line      = in_address[ADDR_W-1:OFFSET_BITS];
    dm_slot   = base | (line[IDX_W-1:0] & mask);
    cmp_tag   = cfg.fully_assoc ? line : (line >> k);
  end

  // Every cell compares against the same tag; the selection differs by mode.
  always_comb begin
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      logic [IDX_W-1:0] ival;
      logic             sel;
      ival     = IDX_W'(i);
      sel      = cfg.fully_assoc ? ((ival & ~mask) == base) : (ival == dm_slot);
      match[i] = valid_r[i] && sel && (tag_cell[i] == cmp_tag);
    end
  end

  // Replacement choice for the update cycle.
  logic [MAX_BLOCKS-1:0] free;
  logic                  any_free;
  logic [IDX_W-1:0]      first_free;
  logic [IDX_W-1:0]      fifo_cur;
  logic [IDX_W-1:0]      wr_slot;

  always_comb begin
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      free[i] = !valid_r[i] && ((IDX_W'(i) & ~mask_r) == base_r);
    end
    any_free   = |free;
    first_free = '0;
    for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
      if (free[i]) begin
        first_free = IDX_W'(i);
      end
    end
    fifo_cur = fifo_r[which_r] & mask_r;
    if (!fa_r) begin
      wr_slot = slot_r;
    end else if (any_free) begin
      wr_slot = first_free;
    end else begin
      wr_slot = base_r | fifo_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      hit_pend_r <= |match;
      tag_r      <= cmp_tag;
      slot_r     <= dm_slot;
      base_r     <= base;
      mask_r     <= mask;
      which_r    <= which;
      fa_r       <= cfg.fully_assoc;
    end
    if (cmd.update && !hit_pend_r) begin
      tag_cell[wr_slot] <= tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      fifo_r[0] <= '0;
      fifo_r[1] <= '0;
      acc_cnt_r <= '0;
      hit_cnt_r <= '0;
      out_hit_r <= 1'b0;
    end else if (cmd.update) begin
      acc_cnt_r <= acc_cnt_r + CNT_W'(1);
      hit_cnt_r <= hit_cnt_r + CNT_W'(hit_pend_r);
      out_hit_r <= hit_pend_r;
      if (!hit_pend_r) begin
        valid_r[wr_slot] <= 1'b1;
        if (fa_r && !any_free) begin
          fifo_r[which_r] <= (fifo_cur + IDX_W'(1)) & mask_r;
        end
      end
    end
  end

  assign out_hit          = out_hit_r;
  assign out_access_total = acc_cnt_r;
  assign out_hit_total    = hit_cnt_r;

endmodule

// ===== rtl/core/cache_hit_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// Cache hit tracker unit
// Tag-only hit model of a direct-mapped or fully associative FIFO cache.
// ----------------------------------------------------------------------------
// Usage:
//   A word (in_address, in_is_instruction) is taken at a rising edge where
//   start is high and busy is low. The block compares the line tag against
//   every tag cell in that same edge, then, in the update state, writes the
//   tag on a miss and bumps the access and hit totals. The result (out_hit,
//   out_access_total, out_hit_total) is shown for one cycle with out_valid
//   high, from registers written in the update state. The receiver cannot
//   stall; a result not taken in that cycle is gone. A new word cannot be
//   taken while the last is in its update: busy is high in the update state,
//   which must finish its tag and valid-bit write before the next word can
//   be compared against the cells. Configuration is written through cfg_we,
//   cfg_index and cfg_wdata while the block is idle, a rule for the user
//   that the block does not enforce. Index 0 selects fully associative
//   placement, index 1 splits the blocks into data and instruction halves,
//   and index 2 gives log2 of the block count, clamped to the range the
//   cache supports. Reset clears the valid bits, both FIFO pointers and the
//   totals, and resets the configuration at once; no clearing pass is needed
//   and start may be raised in the first cycle after reset.
// ----------------------------------------------------------------------------
module cache_hit_tracker_unit import chtrk_pkg::*; #(
  parameter int MAX_BLOCKS  = DEF_MAX_BLOCKS,
  parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [ADDR_W-1:0]     in_address,
  input  logic                  in_is_instruction,
  output logic                  out_valid,
  output logic                  out_hit,
  output logic [CNT_W-1:0]      out_access_total,
  output logic [CNT_W-1:0]      out_hit_total,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  chtrk_cfg_t cfg_r;
  chtrk_cmd_t cmd;

  // Configuration registers. Unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fully_assoc <= 1'b0;
      cfg_r.split       <= 1'b0;
      cfg_r.blocks_log2 <= BLOCKS_LOG2_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FULLY_ASSOC: cfg_r.fully_assoc <= cfg_wdata[0];
        REG_SPLIT:       cfg_r.split       <= cfg_wdata[0];
        REG_BLOCKS_LOG2: cfg_r.blocks_log2 <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // The controller sequences compare and update; it sees only start.
  chtrk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // The datapath holds the tag cells, valid bits, FIFO pointers and totals.
  chtrk_datapath #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg               (cfg_r),
    .in_address        (in_address),
    .in_is_instruction (in_is_instruction),
    .out_hit           (out_hit),
    .out_access_total  (out_access_total),
    .out_hit_total     (out_hit_total)
  );

endmodule

// ===== rtl/core/chtrk_checker.sv =====
// ----------------------------------------------------------------------------
// Cache hit tracker checker
// Port-level checks of the sequencing and of the running totals.
// ----------------------------------------------------------------------------
module chtrk_checker import chtrk_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             out_valid,
  input logic             out_hit,
  input logic [CNT_W-1:0] out_access_total,
  input logic [CNT_W-1:0] out_hit_total
);

  // An accepted word keeps the block busy for the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // The update cycle is followed by exactly one result.
  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (out_valid && !busy))
    else $error("update cycle not followed by a result");

  // Each result counts one more access.
  a_access_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_access_total == $past(out_access_total) + CNT_W'(1)))
    else $error("access total did not advance by one");

  // The hit total advances exactly when the result is a hit.
  a_hit_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hit_total == $past(out_hit_total) + CNT_W'(out_hit)))
    else $error("hit total does not follow the hit flag");

endmodule

bind cache_hit_tracker_unit chtrk_checker u_chtrk_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_hit          (out_hit),
  .out_access_total (out_access_total),
  .out_hit_total    (out_hit_total)
);
